>>> design/fdpc_pkg.sv
// Shared widths, constants and handshake structs of the divider parameter calculator.
package fdpc_pkg;

    localparam int TgtWidth     = 28;
    localparam int PllWidth     = 31;
    localparam int DivWidth     = 31;
    localparam int DivSteps     = DivWidth;
    localparam int DivCntWidth  = $clog2(DivSteps);
    localparam int GcdKWidth    = $clog2(TgtWidth);
    localparam int P1Width      = 18;
    localparam int P20Width     = 20;
    localparam int QuoWidth     = 8;
    localparam int ScaleShift   = 7;
    localparam int AddrWidth    = 3;
    localparam int DefDenomBits = 20;
    localparam int MaxDenomBits = 24;

    localparam logic [PllWidth-1:0] PllReset  = 31'd900000000;
    localparam logic [P1Width-1:0]  P1Offset  = 18'd512;
    localparam logic [PllWidth-1:0] DivFour   = 31'd4;
    localparam logic                RegPll    = 1'b0;

    typedef struct packed {
        logic                start;
        logic [DivWidth-1:0] dividend;
        logic [TgtWidth-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DivWidth-1:0] quotient;
        logic [TgtWidth-1:0] remainder;
    } t_div_rsp;

    typedef struct packed {
        logic                start;
        logic [TgtWidth-1:0] x;
        logic [TgtWidth-1:0] y;
    } t_gcd_req;

    typedef struct packed {
        logic                done;
        logic [TgtWidth-1:0] g;
    } t_gcd_rsp;

endpackage

>>> design/fdpc_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions of the block.
module fdpc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fdpc_pkg::t_div_req i_req,
    output fdpc_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [fdpc_pkg::DivCntWidth-1:0]    r_cnt;
    logic [fdpc_pkg::TgtWidth-1:0]       r_rem;
    logic [fdpc_pkg::TgtWidth-1:0]       r_dsr;
    logic [fdpc_pkg::DivWidth-1:0]       r_quo;
    logic [fdpc_pkg::TgtWidth:0]         trial;
    logic [fdpc_pkg::TgtWidth:0]         diff;
    logic                                ge;

    assign trial = {r_rem, r_quo[fdpc_pkg::DivWidth-1]};
    assign ge    = trial >= {1'b0, r_dsr};
    assign diff  = trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == fdpc_pkg::DivCntWidth'(fdpc_pkg::DivSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[fdpc_pkg::TgtWidth-1:0] : trial[fdpc_pkg::TgtWidth-1:0];
            r_quo <= {r_quo[fdpc_pkg::DivWidth-2:0], ge};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

>>> design/fdpc_gcd.sv
// Binary greatest common divisor, one shift or subtract step per cycle.
module fdpc_gcd (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fdpc_pkg::t_gcd_req i_req,
    output fdpc_pkg::t_gcd_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [fdpc_pkg::GcdKWidth-1:0] r_k;
    logic [fdpc_pkg::TgtWidth-1:0]  r_x;
    logic [fdpc_pkg::TgtWidth-1:0]  r_y;
    logic [fdpc_pkg::TgtWidth-1:0]  r_g;
    logic                           x_ge;
    logic [fdpc_pkg::TgtWidth-1:0]  diff;

    assign x_ge = r_x >= r_y;
    assign diff = x_ge ? (r_x - r_y) : (r_y - r_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_x == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= i_req.x;
            r_y <= i_req.y;
            r_k <= '0;
        end else if (r_busy) begin
            priority if (r_x == '0) begin
                r_g <= r_y << r_k;
            end else if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (x_ge) begin
                r_x <= diff >> 1;
            end else begin
                r_y <= diff >> 1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.g    = r_g;

endmodule

>>> design/fractional_divider_parameter_calc.sv
// Top level: APB register, stream ports and the sequencer of the parameter calculator.
//
// Usage: software writes the PLL frequency in hertz to the register at byte address 0
// over APB (reset value 900000000), then sends one target frequency per input word on
// s_axis (tdata bits 27:0). For each word one result word leaves on m_axis with P1, P2
// and P3 in tdata and the integer-mode and divide-by-four flags in tuser.
// Each nonzero word runs through one shared restoring divider (four divisions), a binary
// gcd unit and then halving of the fraction until its denominator fits in DENOM_BITS
// bits. A zero target skips the divisions and goes straight to the finish step.
// The block returns to idle when the result is registered.
// s_axis_tready is high only
// while no word is in work; one finished result can wait in the output register while
// the next word is taken. If the receiver stalls, the next result waits inside the
// block and no further word is accepted until the output register frees. Reset is
// synchronous, active low: it drops any word in work, clears the output valid and
// restores the register's reset value.
module fractional_divider_parameter_calc #(
    parameter int DENOM_BITS = fdpc_pkg::DefDenomBits
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fdpc_pkg::AddrWidth-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // target_frequency[27:0]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [63:0]                    m_axis_tdata,  // param_one, param_two, param_three
    output logic [1:0]                     m_axis_tuser   // integer_mode, divide_by_four
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_A,
        S_GCD,
        S_DIV_C,
        S_DIV_B,
        S_SHIFT,
        S_DIV_Q,
        S_FIN
    } t_state;

    t_state                            r_state;
    logic [fdpc_pkg::PllWidth-1:0]     r_pll;
    logic                              r_zero;
    logic [fdpc_pkg::TgtWidth-1:0]     r_tgt;
    logic [fdpc_pkg::PllWidth-1:0]     r_a;
    logic [fdpc_pkg::TgtWidth-1:0]     r_b;
    logic [fdpc_pkg::TgtWidth-1:0]     r_c;
    logic [fdpc_pkg::TgtWidth-1:0]     r_g;
    logic [fdpc_pkg::QuoWidth-1:0]     r_q;
    logic [fdpc_pkg::P20Width-1:0]     r_p2;
    logic                              r_div_start;
    logic [fdpc_pkg::DivWidth-1:0]     r_div_dividend;
    logic [fdpc_pkg::TgtWidth-1:0]     r_div_divisor;
    logic                              r_gcd_start;
    logic                              r_out_valid;
    logic [fdpc_pkg::P1Width-1:0]      r_out_p1;
    logic [fdpc_pkg::P20Width-1:0]     r_out_p2;
    logic [fdpc_pkg::P20Width-1:0]     r_out_p3;
    logic                              r_out_imode;
    logic                              r_out_div4;

    fdpc_pkg::t_div_req                div_req;
    fdpc_pkg::t_div_rsp                div_rsp;
    fdpc_pkg::t_gcd_req                gcd_req;
    fdpc_pkg::t_gcd_rsp                gcd_rsp;

    logic                              cfg_wr;
    logic                              in_acc;
    logic                              out_free;
    logic                              c_wide;
    logic [fdpc_pkg::P1Width-1:0]      a_scaled;
    logic [fdpc_pkg::P1Width-1:0]      n_p1;
    logic [fdpc_pkg::P20Width-1:0]     n_p2;
    logic [fdpc_pkg::P20Width-1:0]     n_p3;
    logic                              n_imode;
    logic                              n_div4;

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_div_dividend;
    assign div_req.divisor  = r_div_divisor;
    assign gcd_req.start    = r_gcd_start;
    assign gcd_req.x        = r_b;
    assign gcd_req.y        = r_c;

    fdpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fdpc_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (gcd_req),
        .o_rsp   (gcd_rsp)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == fdpc_pkg::RegPll);
    assign prdata   = (paddr[2] == fdpc_pkg::RegPll) ? {1'b0, r_pll} : 32'd0;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign c_wide        = |(r_c >> DENOM_BITS);

    assign a_scaled = {r_a[fdpc_pkg::P1Width-fdpc_pkg::ScaleShift-1:0],
                       fdpc_pkg::ScaleShift'(0)};

    always_comb begin
        n_imode = (r_b == '0);
        n_div4  = (r_a == fdpc_pkg::DivFour);
        n_p1    = '0;
        n_p2    = '0;
        n_p3    = fdpc_pkg::P20Width'(1);
        priority if (r_zero) begin
            n_imode = 1'b1;
            n_div4  = 1'b0;
        end else if (n_div4) begin
            n_p1 = '0;
        end else if (n_imode) begin
            n_p1 = a_scaled - fdpc_pkg::P1Offset;
        end else begin
            n_p1 = a_scaled + fdpc_pkg::P1Width'(r_q) - fdpc_pkg::P1Offset;
            n_p2 = r_p2;
            n_p3 = r_c[fdpc_pkg::P20Width-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pll       <= fdpc_pkg::PllReset;
            r_div_start <= 1'b0;
            r_gcd_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_gcd_start <= 1'b0;
            if (cfg_wr) begin
                r_pll <= pwdata[fdpc_pkg::PllWidth-1:0];
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_tgt  <= s_axis_tdata[fdpc_pkg::TgtWidth-1:0];
                        r_zero <= (s_axis_tdata[fdpc_pkg::TgtWidth-1:0] == '0);
                        if (s_axis_tdata[fdpc_pkg::TgtWidth-1:0] == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_div_start    <= 1'b1;
                            r_div_dividend <= r_pll;
                            r_div_divisor  <= s_axis_tdata[fdpc_pkg::TgtWidth-1:0];
                            r_state        <= S_DIV_A;
                        end
                    end
                end
                S_DIV_A: begin
                    if (div_rsp.done) begin
                        r_a         <= div_rsp.quotient;
                        r_b         <= div_rsp.remainder;
                        r_c         <= r_tgt;
                        r_gcd_start <= 1'b1;
                        r_state     <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (gcd_rsp.done) begin
                        r_g            <= gcd_rsp.g;
                        r_div_start    <= 1'b1;
                        r_div_dividend <= fdpc_pkg::DivWidth'(r_c);
                        r_div_divisor  <= gcd_rsp.g;
                        r_state        <= S_DIV_C;
                    end
                end
                S_DIV_C: begin
                    if (div_rsp.done) begin
                        r_c            <= div_rsp.quotient[fdpc_pkg::TgtWidth-1:0];
                        r_div_start    <= 1'b1;
                        r_div_dividend <= fdpc_pkg::DivWidth'(r_b);
                        r_div_divisor  <= r_g;
                        r_state        <= S_DIV_B;
                    end
                end
                S_DIV_B: begin
                    if (div_rsp.done) begin
                        r_b     <= div_rsp.quotient[fdpc_pkg::TgtWidth-1:0];
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (c_wide) begin
                        r_b <= r_b >> 1;
                        r_c <= r_c >> 1;
                    end else begin
                        r_div_start    <= 1'b1;
                        r_div_dividend <= {r_b[fdpc_pkg::MaxDenomBits-1:0],
                                           fdpc_pkg::ScaleShift'(0)};
                        r_div_divisor  <= r_c;
                        r_state        <= S_DIV_Q;
                    end
                end
                S_DIV_Q: begin
                    if (div_rsp.done) begin
                        r_q     <= div_rsp.quotient[fdpc_pkg::QuoWidth-1:0];
                        r_p2    <= div_rsp.remainder[fdpc_pkg::P20Width-1:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_p1    <= n_p1;
                        r_out_p2    <= n_p2;
                        r_out_p3    <= n_p3;
                        r_out_imode <= n_imode;
                        r_out_div4  <= n_div4;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_p3, r_out_p2, r_out_p1};
    assign m_axis_tuser  = {r_out_div4, r_out_imode};

`ifndef SYNTHESIS
    a_div4_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[57:0] == {20'd1, 38'd0})
        else $error("divide-by-four word carries nonzero P1/P2 or P3 != 1");

    a_int_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[57:18] == {20'd1, 20'd0})
        else $error("integer-mode word carries P2 != 0 or P3 != 1");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_FIN)
        else $error("output word raised outside the finish step");
`endif

endmodule

>>> test/testbench.sv
// Testbench for the fractional divider parameter calculator: stream stimulus, APB setup, checking.
`timescale 1ns / 100ps

module testbench;

    localparam int DenomBits = fdpc_pkg::DefDenomBits;
    localparam int Phases = 9;
    localparam int ItemsPerPhase = 100;
    localparam int HoldCycles = 800;
    localparam int DrainCycles = 250;
    localparam logic [fdpc_pkg::AddrWidth-1:0] PllAddr = {fdpc_pkg::RegPll, 2'b00};
    localparam logic [fdpc_pkg::AddrWidth-1:0] SpareAddr = 3'd4;
    localparam logic [fdpc_pkg::TgtWidth-1:0] TgtMax = '1;

    typedef struct packed {
        logic [fdpc_pkg::P1Width-1:0]  p1;
        logic [fdpc_pkg::P20Width-1:0] p2;
        logic [fdpc_pkg::P20Width-1:0] p3;
        logic                          imode;
        logic                          div4;
    } t_divider_params;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [fdpc_pkg::AddrWidth-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // target_frequency[27:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // param_one[17:0], param_two[37:18], param_three[57:38]
    logic [1:0]  m_axis_tuser;        // integer_mode[0], divide_by_four[1]

    logic [fdpc_pkg::PllWidth-1:0] pll_setting = fdpc_pkg::PllReset;
    logic [fdpc_pkg::TgtWidth-1:0] target_queue[$];
    t_divider_params               params_due[$];
    int unsigned                   tx_idle_pct = 0;
    int unsigned                   rx_idle_pct = 0;
    logic                          hold_go = 1'b0;
    int unsigned                   hold_left = 0;
    int                            errors = 0;

    fractional_divider_parameter_calc u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_divider_params calc_divider_params(
            input logic [fdpc_pkg::PllWidth-1:0] pll,
            input logic [fdpc_pkg::TgtWidth-1:0] tgt);
        longint unsigned whole, num, den, x, y, r, q;
        t_divider_params res;
        res = '{p1: '0, p2: '0, p3: fdpc_pkg::P20Width'(1), imode: 1'b1, div4: 1'b0};
        if (tgt == 0) begin
            return res;
        end
        whole = pll / tgt;
        num = pll - tgt * whole;
        den = tgt;
        x = num;
        y = den;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        num = num / x;
        den = den / x;
        while (den >= (64'd1 << DenomBits)) begin
            num = num >> 1;
            den = den >> 1;
        end
        res.imode = (num == 0);
        res.div4 = (whole == 4);
        if (res.div4) begin
            res.p1 = '0;
        end else if (res.imode) begin
            res.p1 = fdpc_pkg::P1Width'(128 * whole - 512);
        end else begin
            q = (128 * num) / den;
            res.p1 = fdpc_pkg::P1Width'(128 * whole + q - 512);
            res.p2 = fdpc_pkg::P20Width'(128 * num - den * q);
            res.p3 = fdpc_pkg::P20Width'(den);
        end
        return res;
    endfunction

    function automatic logic [fdpc_pkg::TgtWidth-1:0] pick_target(
            input logic [fdpc_pkg::PllWidth-1:0] pll);
        longint unsigned v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = $urandom_range(0, 1000);
            2, 3: v = pll / $urandom_range(1, 2048);
            4: v = (pll >> 2) + $urandom_range(0, 15);
            default: v = pll / $urandom_range(3, 600) + $urandom_range(0, 999);
        endcase
        return fdpc_pkg::TgtWidth'(v);
    endfunction

    // stream sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (target_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'b0, target_queue.pop_front()};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HoldCycles;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // monitor: predict on accept, compare on result
    always @(posedge i_clk) begin
        t_divider_params want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (params_due.size() == 0) begin
                    $error("result word with nothing expected: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    want = params_due.pop_front();
                    if (m_axis_tdata[17:0] !== want.p1) begin
                        $error("param_one: expected %0d, got %0d", want.p1, m_axis_tdata[17:0]);
                        errors++;
                    end
                    if (m_axis_tdata[37:18] !== want.p2) begin
                        $error("param_two: expected %0d, got %0d", want.p2, m_axis_tdata[37:18]);
                        errors++;
                    end
                    if (m_axis_tdata[57:38] !== want.p3) begin
                        $error("param_three: expected %0d, got %0d", want.p3,
                               m_axis_tdata[57:38]);
                        errors++;
                    end
                    if (m_axis_tuser[0] !== want.imode) begin
                        $error("integer_mode: expected %0d, got %0d", want.imode,
                               m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tuser[1] !== want.div4) begin
                        $error("divide_by_four: expected %0d, got %0d", want.div4,
                               m_axis_tuser[1]);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                params_due.push_back(calc_divider_params(
                    pll_setting, s_axis_tdata[fdpc_pkg::TgtWidth-1:0]));
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [fdpc_pkg::AddrWidth-1:0] addr,
                              input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (!wr && prdata !== {1'b0, pll_setting}) begin
            $error("pll_frequency readback: expected %0d, got %0d", pll_setting, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (wr && addr == PllAddr) begin
            pll_setting = data[fdpc_pkg::PllWidth-1:0];
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (target_queue.size() != 0 || s_axis_tvalid || params_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        logic [31:0]                   phase_pll [Phases];
        int unsigned                   phase_mode [Phases];
        logic [fdpc_pkg::TgtWidth-1:0] directed [16];
        phase_pll = '{32'd900000000, 32'd1, 32'h7FFF_FFFF, 32'd0, 32'd805306366,
                      32'h8000_0000 | 32'd27000000, 32'd0, 32'd0, 32'd25000000};
        phase_mode = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
        directed = '{28'd0, 28'd1, 28'd2, 28'd3, 28'd7, TgtMax, 28'd225000000,
                     28'd225000001, 28'd112500000, 28'd200000000, 28'd150000000,
                     28'd268435455, 28'd12345678, 28'd1000000, 28'd25000000, 28'd33333333};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < Phases; ph++) begin
            wait_idle();
            @(posedge i_clk);
            tx_idle_pct <= (phase_mode[ph] == 0) ? 14 : (phase_mode[ph] == 1) ? 69 : 0;
            rx_idle_pct <= (phase_mode[ph] == 0) ? 69 : (phase_mode[ph] == 1) ? 14 : 0;
            if (ph == 6) begin
                // a write past the register map must leave the setting alone
                apb_access(1'b1, SpareAddr, $urandom);
                apb_access(1'b0, PllAddr, '0);
            end
            if (ph >= 6) begin
                phase_pll[ph] = 32'($urandom_range(1, 32'h7FFF_FFFF));
            end
            if (ph != 0) begin
                apb_access(1'b1, PllAddr, phase_pll[ph]);
                apb_access(1'b0, PllAddr, '0);
            end
            if (ph == 0) begin
                foreach (directed[k]) target_queue.push_back(directed[k]);
            end
            if (ph == 4) begin
                // remainder of one over a wide denominator halves away to zero
                target_queue.push_back(TgtMax);
                target_queue.push_back(TgtMax - 1);
            end
            for (int k = 0; k < ItemsPerPhase; k++) begin
                target_queue.push_back(pick_target(pll_setting));
            end
            if (ph == 6) begin
                @(posedge i_clk);
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
        end
        wait_idle();
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
